### hdl/vtpd_pkg.sv
// Shared widths, types and helpers for the vertex transform block.
package vtpd_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int COEF_WIDTH  = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int PROD_WIDTH  = COEF_WIDTH + COORD_WIDTH;
    localparam int ACC_WIDTH   = PROD_WIDTH + 2;
    localparam int NUM_WIDTH   = ACC_WIDTH + FRAC_BITS;
    localparam int NUM_REGS    = 8;
    localparam int LANES       = 3;

    typedef logic [3:0][3:0][COEF_WIDTH-1:0] coef_mat_t;
    typedef logic [3:0][ACC_WIDTH-1:0]       acc_vec_t;

    // One divider lane: partial remainder, dividend bits still to shift in,
    // quotient so far and sign of the final result.
    typedef struct packed {
        logic [ACC_WIDTH-1:0] rem;
        logic [NUM_WIDTH-1:0] num;
        logic [NUM_WIDTH-1:0] quo;
        logic                 neg;
    } lane_t;

    typedef struct packed {
        logic                 valid;
        logic                 wz;
        logic [ACC_WIDTH-1:0] den;
        lane_t [LANES-1:0]    lane;
    } stage_t;

endpackage

### hdl/vertex_transform_perspective_divide.sv
// Vertex transform with perspective divide: top level.
// Registers in order: products, row sums, prep, the divider cells and the output; one item per cycle.
// Throughput: one vertex every clock, set by the fully pipelined multiply stage
// and the chain of 82 one-bit divider cells (one quotient bit per cell).
// busy stays low; results cannot be stalled by the receiver.
// Reset: asynchronous, active low; matrix returns to identity, pipeline empties.
module vertex_transform_perspective_divide
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [vtpd_pkg::COORD_WIDTH-1:0] x_in,
    input  logic signed [vtpd_pkg::COORD_WIDTH-1:0] y_in,
    input  logic signed [vtpd_pkg::COORD_WIDTH-1:0] z_in,
    output logic                                   done,
    output logic signed [vtpd_pkg::COORD_WIDTH-1:0] x_out,
    output logic signed [vtpd_pkg::COORD_WIDTH-1:0] y_out,
    output logic signed [vtpd_pkg::COORD_WIDTH-1:0] z_out,
    output logic                                   w_zero,
    output logic                                   overflow,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [5:0]                             paddr,
    input  logic [63:0]                            pwdata,
    output logic [63:0]                            prdata,
    output logic                                   pready
);

    localparam int CW  = vtpd_pkg::COORD_WIDTH;
    localparam int NW  = vtpd_pkg::NUM_WIDTH;
    localparam int AW  = vtpd_pkg::ACC_WIDTH;
    localparam int LAT = NW + 4;
    localparam logic [63:0] ONE = 64'(1) << vtpd_pkg::FRAC_BITS;
    localparam logic [NW-1:0] LIM = NW'(1) << (CW - 1);

    // Matrix registers, two coefficients each.
    logic [63:0] mat_reg [vtpd_pkg::NUM_REGS];
    logic        cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = mat_reg[paddr[5:3]];
    assign busy   = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[0] <= ONE;
            mat_reg[1] <= '0;
            mat_reg[2] <= ONE << 32;
            mat_reg[3] <= '0;
            mat_reg[4] <= '0;
            mat_reg[5] <= ONE;
            mat_reg[6] <= '0;
            mat_reg[7] <= ONE << 32;
        end
        else if (cfg_wr)
            mat_reg[paddr[5:3]] <= pwdata;
    end

    // Split registers into coefficients: low half even column, high half odd.
    vtpd_pkg::coef_mat_t coef;
    always_comb
    begin
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
            begin
                logic [63:0] w;
                w = mat_reg[r*2 + c/2];
                if ((c % 2) == 1)
                    coef[r][c] = w[32 +: vtpd_pkg::COEF_WIDTH];
                else
                    coef[r][c] = w[0 +: vtpd_pkg::COEF_WIDTH];
            end
    end

    logic               in_acc;
    logic               acc_valid;
    vtpd_pkg::acc_vec_t acc;
    assign in_acc = start && !busy;

    vtpd_mac u_mac
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (in_acc),
        .x_in      (x_in),
        .y_in      (y_in),
        .z_in      (z_in),
        .coef      (coef),
        .acc_valid (acc_valid),
        .acc       (acc)
    );

    // Take magnitudes and signs, load the first divider cell.
    vtpd_pkg::stage_t prep_reg;
    vtpd_pkg::stage_t prep_next;
    always_comb
    begin
        logic [AW-1:0] m;
        prep_next.valid = acc_valid;
        prep_next.wz    = (acc[3] == '0);
        prep_next.den   = acc[3][AW-1] ? AW'(-acc[3]) : acc[3];
        for (int l = 0; l < vtpd_pkg::LANES; l++)
        begin
            m = acc[l][AW-1] ? AW'(-acc[l]) : acc[l];
            prep_next.lane[l].rem = '0;
            prep_next.lane[l].num = {m, {vtpd_pkg::FRAC_BITS{1'b0}}};
            prep_next.lane[l].quo = '0;
            prep_next.lane[l].neg = acc[l][AW-1] ^ acc[3][AW-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_reg <= '0;
        else
            prep_reg <= prep_next;
    end

    // Chain of cells: each resolves one quotient bit and hands the item on.
    vtpd_pkg::stage_t chain [NW+1];
    assign chain[0] = prep_reg;

    for (genvar g = 0; g < NW; g++)
    begin : g_cell
        vtpd_div_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .d     (chain[g]),
            .q     (chain[g+1])
        );
    end

    // Saturate, apply sign, drop values for zero w.
    vtpd_pkg::stage_t           fin;
    logic [2:0][CW-1:0]         res_next;
    logic                       ovf_next;
    logic [2:0][CW-1:0]         res_reg;
    logic                       ovf_reg;
    logic                       wz_reg;
    logic                       done_reg;
    assign fin = chain[NW];

    always_comb
    begin
        ovf_next = 1'b0;
        for (int l = 0; l < vtpd_pkg::LANES; l++)
        begin
            logic [NW-1:0] qv;
            qv = fin.lane[l].quo;
            if (fin.lane[l].neg)
            begin
                if (qv > LIM)
                begin
                    ovf_next    = 1'b1;
                    res_next[l] = LIM[CW-1:0];
                end
                else
                    res_next[l] = CW'(-qv);
            end
            else
            begin
                if (qv > LIM - NW'(1))
                begin
                    ovf_next    = 1'b1;
                    res_next[l] = CW'(LIM - NW'(1));
                end
                else
                    res_next[l] = qv[CW-1:0];
            end
            if (fin.wz)
                res_next[l] = '0;
        end
        if (fin.wz)
            ovf_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= fin.valid;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        ovf_reg <= ovf_next;
        wz_reg  <= fin.wz;
    end

    assign done     = done_reg;
    assign x_out    = res_reg[0];
    assign y_out    = res_reg[1];
    assign z_out    = res_reg[2];
    assign w_zero   = wz_reg;
    assign overflow = ovf_reg;

    // Every strobe traces back to an accepted item.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_acc, LAT))
        else $error("result strobe without matching item");

    a_wz_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && w_zero) |-> (!overflow && x_out == '0 && y_out == '0 && z_out == '0))
        else $error("zero w result not cleared");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> ##LAT done)
        else $error("accepted item lost in pipeline");

endmodule

### hdl/vtpd_mac.sv
// Matrix-vector multiply and row sums, two register stages.
module vtpd_mac
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   valid,
    input  logic signed [vtpd_pkg::COORD_WIDTH-1:0] x_in,
    input  logic signed [vtpd_pkg::COORD_WIDTH-1:0] y_in,
    input  logic signed [vtpd_pkg::COORD_WIDTH-1:0] z_in,
    input  vtpd_pkg::coef_mat_t                    coef,
    output logic                                   acc_valid,
    output vtpd_pkg::acc_vec_t                     acc
);

    logic signed [vtpd_pkg::PROD_WIDTH-1:0] prod_reg [4][3];
    logic signed [vtpd_pkg::ACC_WIDTH-1:0]  bias_reg [4];
    logic signed [vtpd_pkg::PROD_WIDTH-1:0] prod_next [4][3];
    logic signed [vtpd_pkg::ACC_WIDTH-1:0]  bias_next [4];
    logic signed [vtpd_pkg::PROD_WIDTH-1:0] va [3];
    logic                                   pv_reg;
    logic                                   acc_valid_reg;
    vtpd_pkg::acc_vec_t                     acc_reg;
    vtpd_pkg::acc_vec_t                     acc_next;

    always_comb
    begin
        va[0] = x_in;
        va[1] = y_in;
        va[2] = z_in;
        for (int r = 0; r < 4; r++)
        begin
            logic signed [vtpd_pkg::PROD_WIDTH-1:0] cw;
            logic signed [vtpd_pkg::ACC_WIDTH-1:0]  c3;
            c3 = $signed(coef[r][3]);
            bias_next[r] = c3 <<< vtpd_pkg::FRAC_BITS;
            for (int c = 0; c < 3; c++)
            begin
                cw = $signed(coef[r][c]);
                prod_next[r][c] = cw * va[c];
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            logic signed [vtpd_pkg::ACC_WIDTH-1:0] p0, p1, p2;
            p0 = prod_reg[r][0];
            p1 = prod_reg[r][1];
            p2 = prod_reg[r][2];
            acc_next[r] = p0 + p1 + p2 + bias_reg[r];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg        <= 1'b0;
            acc_valid_reg <= 1'b0;
        end
        else
        begin
            pv_reg        <= valid;
            acc_valid_reg <= pv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        bias_reg <= bias_next;
        acc_reg  <= acc_next;
    end

    assign acc_valid = acc_valid_reg;
    assign acc       = acc_reg;

endmodule

### hdl/vtpd_div_cell.sv
// One restoring-division step for all three lanes; registered hand-off.
module vtpd_div_cell
(
    input  logic             clk,
    input  logic             rst_n,
    input  vtpd_pkg::stage_t d,
    output vtpd_pkg::stage_t q
);

    vtpd_pkg::stage_t st_reg;
    vtpd_pkg::stage_t st_next;

    always_comb
    begin
        st_next = d;
        for (int l = 0; l < vtpd_pkg::LANES; l++)
        begin
            logic [vtpd_pkg::ACC_WIDTH:0] trial;
            logic [vtpd_pkg::ACC_WIDTH:0] diff;
            trial = {d.lane[l].rem, d.lane[l].num[vtpd_pkg::NUM_WIDTH-1]};
            diff  = trial - {1'b0, d.den};
            if (trial >= {1'b0, d.den})
            begin
                st_next.lane[l].rem = diff[vtpd_pkg::ACC_WIDTH-1:0];
                st_next.lane[l].quo = {d.lane[l].quo[vtpd_pkg::NUM_WIDTH-2:0], 1'b1};
            end
            else
            begin
                st_next.lane[l].rem = trial[vtpd_pkg::ACC_WIDTH-1:0];
                st_next.lane[l].quo = {d.lane[l].quo[vtpd_pkg::NUM_WIDTH-2:0], 1'b0};
            end
            st_next.lane[l].num = {d.lane[l].num[vtpd_pkg::NUM_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else
            st_reg <= st_next;
    end

    assign q = st_reg;

endmodule

### tb/sv/vertex_transform_perspective_divide_tb.sv
// Randomized and directed testbench for the vertex transform and perspective divide block.
module vertex_transform_perspective_divide_tb;

    localparam int PERIOD_CYCLES = 20;
    localparam int DRAIN_CYCLES  = 120;
    localparam int NUM_PHASES    = 8;
    localparam int RAND_PER_PHASE = 57;

    typedef logic signed [vtpd_pkg::COORD_WIDTH-1:0] coord_t;

    // One projected vertex as the block should return it.
    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   wz;
        logic   ovf;
    } vertex_res_t;

    // Scoreboard: holds a private copy of the matrix and a queue of projected
    // vertices still to come back from the block.
    class projection_board;
        logic [63:0]  matrix_regs [vtpd_pkg::NUM_REGS];
        vertex_res_t  pending [$];
        int           errors;

        function new();
            errors = 0;
            reset_matrix();
        endfunction

        // Identity matrix, 1.0 = 1 << FRAC_BITS.
        function void reset_matrix();
            foreach (matrix_regs[i]) matrix_regs[i] = '0;
            matrix_regs[0] = 64'(1) << vtpd_pkg::FRAC_BITS;
            matrix_regs[2] = 64'(1) << (vtpd_pkg::FRAC_BITS + 32);
            matrix_regs[5] = 64'(1) << vtpd_pkg::FRAC_BITS;
            matrix_regs[7] = 64'(1) << (vtpd_pkg::FRAC_BITS + 32);
        endfunction

        function void write_reg(int idx, logic [63:0] value);
            if (idx < vtpd_pkg::NUM_REGS) matrix_regs[idx] = value;
        endfunction

        function logic signed [127:0] coef_of(int row, int col);
            logic [63:0] r;
            logic [31:0] half;
            r    = matrix_regs[row * 2 + col / 2];
            half = (col % 2) ? r[63:32] : r[31:0];
            return 128'(signed'(half[vtpd_pkg::COEF_WIDTH-1:0]));
        endfunction

        // Exact row sums, then each of x, y, z divided by w with saturation.
        function vertex_res_t project_vertex(coord_t x, coord_t y, coord_t z);
            logic signed [127:0] acc [4];
            logic signed [127:0] vx, vy, vz, quo, hi_lim, lo_lim;
            coord_t      res [3];
            vertex_res_t pr;
            vx = 128'(x);
            vy = 128'(y);
            vz = 128'(z);
            hi_lim = (128'sd1 <<< (vtpd_pkg::COORD_WIDTH - 1)) - 1;
            lo_lim = -(128'sd1 <<< (vtpd_pkg::COORD_WIDTH - 1));
            for (int r = 0; r < 4; r++)
                acc[r] = (coef_of(r, 3) <<< vtpd_pkg::FRAC_BITS) + coef_of(r, 0) * vx
                         + coef_of(r, 1) * vy + coef_of(r, 2) * vz;
            pr.ovf = 1'b0;
            pr.wz  = (acc[3] == 0);
            for (int r = 0; r < 3; r++)
            begin
                if (pr.wz)
                begin
                    res[r] = '0;
                end
                else
                begin
                    // SystemVerilog signed division truncates toward zero
                    quo = (acc[r] <<< vtpd_pkg::FRAC_BITS) / acc[3];
                    if (quo > hi_lim)
                    begin
                        quo = hi_lim;
                        pr.ovf = 1'b1;
                    end
                    else if (quo < lo_lim)
                    begin
                        quo = lo_lim;
                        pr.ovf = 1'b1;
                    end
                    res[r] = quo[vtpd_pkg::COORD_WIDTH-1:0];
                end
            end
            pr.x = res[0];
            pr.y = res[1];
            pr.z = res[2];
            return pr;
        endfunction

        function void note_vertex(coord_t x, coord_t y, coord_t z);
            pending.push_back(project_vertex(x, y, z));
        endfunction

        function void check_result(coord_t x, coord_t y, coord_t z, logic wz, logic ovf);
            vertex_res_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result x=%h y=%h z=%h w_zero=%b overflow=%b",
                         $time, x, y, z, wz, ovf);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (x !== e.x)
            begin
                $display("%0t: x_out expected %h actual %h", $time, e.x, x);
                errors++;
            end
            if (y !== e.y)
            begin
                $display("%0t: y_out expected %h actual %h", $time, e.y, y);
                errors++;
            end
            if (z !== e.z)
            begin
                $display("%0t: z_out expected %h actual %h", $time, e.z, z);
                errors++;
            end
            if (wz !== e.wz)
            begin
                $display("%0t: w_zero expected %b actual %b", $time, e.wz, wz);
                errors++;
            end
            if (ovf !== e.ovf)
            begin
                $display("%0t: overflow expected %b actual %b", $time, e.ovf, ovf);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    coord_t      x_in = '0, y_in = '0, z_in = '0;
    logic        done;
    coord_t      x_out, y_out, z_out;
    logic        w_zero, overflow;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    projection_board board = new();

    vertex_transform_perspective_divide i_dut (.*);

    always #(PERIOD_CYCLES / 2) clk = ~clk;

    // Check every result in the cycle its strobe is high.
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result(x_out, y_out, z_out, w_zero, overflow);
    end

    // Write one 64-bit matrix register: setup cycle, then access cycle.
    task automatic write_matrix_reg(int idx, logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 6'(idx * 8);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        // pready is tied high, so the access completes at the next edge
        do @(posedge clk); while (!pready);
        board.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Present one vertex after a random gap; hold start across back-to-back items.
    task automatic send_vertex(coord_t x, coord_t y, coord_t z);
        int gap;
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) gap = 0;   // stretches with no idling
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        x_in  <= x;
        y_in  <= y;
        z_in  <= z;
        do @(posedge clk); while (busy);
        board.note_vertex(x, y, z);
    endtask

    // Mix of small values (so w rarely collapses), extremes and full-range noise.
    function automatic coord_t rand_coord();
        case ($urandom_range(0, 5))
            0, 1:    return coord_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            2:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            3:       return coord_t'($urandom_range(0, 8)) - 4;
            default: return coord_t'($urandom());
        endcase
    endfunction

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 4))
            0, 1:    return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
            2:       return 32'($urandom_range(0, 4)) - 2;
            3:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Pick the matrix for a phase: identity first, then perspective, degenerate
    // w, the coefficient extremes and random matrices.
    function automatic logic [63:0] phase_reg(int phase, int idx);
        case (phase)
            1:       // w = z, plain perspective
                case (idx)
                    0:       return 64'h0000_0000_0001_0000;
                    2:       return 64'h0001_0000_0000_0000;
                    5:       return 64'h0000_0000_0001_0000;
                    7:       return 64'h0000_0000_0001_0000;
                    default: return 64'h0;
                endcase
            2:       return (idx >= 6) ? 64'h0 : {rand_coef(), rand_coef()};   // w always zero
            3:       return 64'hFFFF_FFFF_FFFF_FFFF;
            4:       return 64'h8000_0000_8000_0000;
            5:       return 64'h7FFF_FFFF_7FFF_FFFF;
            default: return {rand_coef(), rand_coef()};
        endcase
    endfunction

    task automatic drain_results();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        coord_t ext [4];
        ext = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 32'sh0001_0000};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            // Reset already loaded the identity; every later phase rewrites all.
            if (phase > 0)
            begin
                for (int idx = 0; idx < vtpd_pkg::NUM_REGS; idx++)
                    write_matrix_reg(idx, phase_reg(phase, idx));
            end
            // Directed corners: twelve mixes of the four extreme coordinate values.
            if (phase < 2)
            begin
                for (int k = 0; k < 12; k++)
                    send_vertex(ext[k % 4], ext[(k / 4) % 4], ext[(k + 1) % 4]);
                send_vertex(32'sh0, 32'sh0, 32'sh1);          // tiny w under perspective
                send_vertex(32'sh0001_0000, 32'sh0, 32'sh0);  // w of zero under perspective
                send_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, -32'sh1);
            end
            for (int n = 0; n < RAND_PER_PHASE; n++)
                send_vertex(rand_coord(), rand_coord(), rand_coord());
            start <= 1'b0;
            drain_results();
        end
        if (board.errors == 0 && board.pending.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    // Hard stop if the block hangs.
    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

endmodule
